// File: hw/rtl/bmfr_pkg.sv
// ----------------------------------------------------------------------------
// bmfr_pkg: shared types and constants of the flash rewrite core
// Transfer payloads, op and status codes, default geometry.
// ----------------------------------------------------------------------------
`default_nettype none

package bmfr_pkg;

  // default array geometry
  localparam int SECTORS_PER_BLOCK = 32;
  localparam int NUM_BLOCKS        = 64;
  localparam int DATA_WIDTH        = 32;

  // fixed field widths
  localparam int ADDR_W  = 11;
  localparam int BLK_W   = 6;
  localparam int WORD_W  = 32;
  localparam int BIU_W   = 7;
  localparam int CNT_W   = 7;
  localparam int PADDR_W = 2;
  localparam int PDATA_W = 32;

  // low byte of an empty sector
  localparam logic [7:0] EMPTY_BYTE = 8'h00;

  // reset value of the blocks-in-use register
  localparam int BIU_RESET = 64;

  // register byte addresses
  localparam logic [PADDR_W-1:0] REG_BLOCKS_IN_USE = 2'd0;

  typedef enum logic [1:0] {
    OP_READ  = 2'd0,
    OP_WRITE = 2'd1,
    OP_ERASE = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_RANGE   = 2'd1,
    ST_NO_FREE = 2'd2
  } status_e;

  typedef struct packed {
    op_e                op;
    logic [ADDR_W-1:0]  sector_address;
    logic [BLK_W-1:0]   block_number;
    logic [WORD_W-1:0]  write_data;
  } in_req_t;

  typedef struct packed {
    status_e            status;
    logic [WORD_W-1:0]  read_data;
    logic [CNT_W-1:0]   program_count;
  } out_rsp_t;

endpackage

`default_nettype wire

// File: hw/rtl/bmfr_ram.sv
// ----------------------------------------------------------------------------
// bmfr_ram: generic simple dual port ram
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module bmfr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 2048
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output      logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// File: hw/rtl/bmfr_cfg.sv
// ----------------------------------------------------------------------------
// bmfr_cfg: configuration register file
// APB-style access to the blocks-in-use register, saturated to the array.
// ----------------------------------------------------------------------------
`default_nettype none

module bmfr_cfg
  import bmfr_pkg::*;
#(
  parameter int NUM_BLOCKS_P = NUM_BLOCKS
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [PDATA_W-1:0] pwdata,
  output      logic [PDATA_W-1:0] prdata,
  output      logic               pready,
  output      logic [BIU_W-1:0]   blocks_in_use_o
);

  localparam int SAT_I = (NUM_BLOCKS_P > 127) ? 127 : NUM_BLOCKS_P;
  localparam logic [BIU_W-1:0] SAT = BIU_W'(SAT_I);
  localparam logic [BIU_W-1:0] RST = (BIU_RESET > SAT_I) ? SAT : BIU_W'(BIU_RESET);

  logic [BIU_W-1:0] biu_q, biu_d;
  logic [BIU_W-1:0] wval;
  logic             wr_en;

  // write decode, every address maps onto the one register
  assign wr_en = psel && penable && pwrite && pready;
  assign wval  = pwdata[BIU_W-1:0];

  always_comb begin
    biu_d = biu_q;
    if (wr_en) begin
      biu_d = (wval > SAT) ? SAT : wval;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      biu_q <= RST;
    end else begin
      biu_q <= biu_d;
    end
  end

  // read data
  always_comb begin
    case (paddr)
      REG_BLOCKS_IN_USE: prdata = PDATA_W'(biu_q);
      default:           prdata = PDATA_W'(biu_q);
    endcase
  end

  assign pready          = 1'b1;
  assign blocks_in_use_o = biu_q;

endmodule

`default_nettype wire

// File: hw/rtl/bmfr_seq.sv
// ----------------------------------------------------------------------------
// bmfr_seq: operation sequencer
// Walks the store one sector per step through the shared ram port for
// reads, writes, spare search, rewrite copies, erases and the clear after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module bmfr_seq
  import bmfr_pkg::*;
#(
  parameter int SECTORS_PER_BLOCK_P = SECTORS_PER_BLOCK,
  parameter int NUM_BLOCKS_P        = NUM_BLOCKS,
  parameter int DATA_WIDTH_P        = DATA_WIDTH,
  localparam int OW = $clog2(SECTORS_PER_BLOCK_P),
  localparam int BW = $clog2(NUM_BLOCKS_P),
  localparam int AW = BW + OW
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic [BIU_W-1:0]        blocks_in_use_i,
  input  wire logic                    in_valid_i,
  output      logic                    in_ready_o,
  input  wire in_req_t                 in_data_i,
  output      logic                    out_valid_o,
  input  wire logic                    out_ready_i,
  output      out_rsp_t                out_data_o,
  output      logic                    ram_we_o,
  output      logic [AW-1:0]           ram_waddr_o,
  output      logic [DATA_WIDTH_P-1:0] ram_wdata_o,
  output      logic [AW-1:0]           ram_raddr_o,
  input  wire logic [DATA_WIDTH_P-1:0] ram_rdata_i
);

  localparam int CW0 = (AW > ADDR_W) ? AW : ADDR_W;
  localparam int CW  = (CW0 > BIU_W + OW) ? CW0 : BIU_W + OW;
  localparam int BCW = (BW + 1 > BIU_W) ? BW + 1 : BIU_W;
  localparam logic [OW-1:0] J_LAST   = OW'(SECTORS_PER_BLOCK_P - 1);
  localparam logic [AW-1:0] CLR_LAST = AW'(SECTORS_PER_BLOCK_P * NUM_BLOCKS_P - 1);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_RD_REQ, S_RD_DATA, S_WR_REQ, S_WR_CHK,
    S_SR_REQ, S_SR_CHK, S_CP_REQ, S_CP_WR, S_BK_REQ, S_BK_WR,
    S_WIPE, S_ERASE, S_DONE
  } state_e;

  state_e                   state_q, state_d;
  logic [AW-1:0]            clr_q, clr_d;
  logic [AW-1:0]            addr_q, addr_d;
  logic [BW-1:0]            blk_q, blk_d;
  logic [BW-1:0]            spare_q, spare_d;
  logic [DATA_WIDTH_P-1:0]  word_q, word_d;
  logic [BCW-1:0]           b_q, b_d;
  logic [OW-1:0]            j_q, j_d;
  status_e                  status_q, status_d;
  logic [WORD_W-1:0]        rdata_q, rdata_d;
  logic [CNT_W-1:0]         cnt_q, cnt_d;
  logic                     out_valid_q, out_valid_d;
  out_rsp_t                 out_q, out_d;

  logic [BIU_W+OW-1:0]      sectors_used;
  logic [CW-1:0]            addr_ext, blk_ext;
  logic                     addr_in_rng, blk_in_rng;
  logic [BW-1:0]            home;
  logic [OW-1:0]            off;
  logic                     rd_full;
  logic [63:0]              rd_wide;

  // range checks on the incoming item
  assign sectors_used = {blocks_in_use_i, {OW{1'b0}}};
  assign addr_ext     = CW'(in_data_i.sector_address);
  assign blk_ext      = CW'(in_data_i.block_number);
  assign addr_in_rng  = addr_ext < CW'(sectors_used);
  assign blk_in_rng   = {1'b0, in_data_i.block_number} < blocks_in_use_i;

  assign home    = addr_q[AW-1:OW];
  assign off     = addr_q[OW-1:0];
  assign rd_full = ram_rdata_i[7:0] != EMPTY_BYTE;
  assign rd_wide = 64'(ram_rdata_i);

  assign in_ready_o = (state_q == S_IDLE);

  // next state and ram access
  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    addr_d      = addr_q;
    blk_d       = blk_q;
    spare_d     = spare_q;
    word_d      = word_q;
    b_d         = b_q;
    j_d         = j_q;
    status_d    = status_q;
    rdata_d     = rdata_q;
    cnt_d       = cnt_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    ram_we_o    = 1'b0;
    ram_waddr_o = addr_q;
    ram_wdata_o = '0;
    ram_raddr_o = addr_q;
    case (state_q)
      S_CLEAR: begin
        ram_we_o    = 1'b1;
        ram_waddr_o = clr_q;
        clr_d       = clr_q + AW'(1);
        if (clr_q == CLR_LAST) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          addr_d   = addr_ext[AW-1:0];
          blk_d    = blk_ext[BW-1:0];
          word_d   = DATA_WIDTH_P'(in_data_i.write_data);
          status_d = ST_OK;
          rdata_d  = '0;
          cnt_d    = '0;
          j_d      = '0;
          b_d      = '0;
          case (in_data_i.op)
            OP_READ: begin
              if (addr_in_rng) state_d = S_RD_REQ;
              else begin
                status_d = ST_RANGE;
                state_d  = S_DONE;
              end
            end
            OP_WRITE: begin
              if (addr_in_rng) state_d = S_WR_REQ;
              else begin
                status_d = ST_RANGE;
                state_d  = S_DONE;
              end
            end
            OP_ERASE: begin
              if (blk_in_rng) state_d = S_ERASE;
              else begin
                status_d = ST_RANGE;
                state_d  = S_DONE;
              end
            end
            default: begin
              status_d = ST_RANGE;
              state_d  = S_DONE;
            end
          endcase
        end
      end
      S_RD_REQ: begin
        state_d = S_RD_DATA;
      end
      S_RD_DATA: begin
        rdata_d = rd_wide[WORD_W-1:0];
        state_d = S_DONE;
      end
      S_WR_REQ: begin
        state_d = S_WR_CHK;
      end
      // program in place or start the spare search
      S_WR_CHK: begin
        if (!rd_full) begin
          ram_we_o    = 1'b1;
          ram_wdata_o = word_q;
          cnt_d       = CNT_W'(1);
          state_d     = S_DONE;
        end else begin
          state_d = S_SR_REQ;
        end
      end
      S_SR_REQ: begin
        ram_raddr_o = {b_q[BW-1:0], j_q};
        if (b_q == BCW'(blocks_in_use_i)) begin
          status_d = ST_NO_FREE;
          state_d  = S_DONE;
        end else if (b_q[BW-1:0] == home) begin
          b_d = b_q + BCW'(1);
        end else begin
          state_d = S_SR_CHK;
        end
      end
      S_SR_CHK: begin
        if (rd_full) begin
          b_d     = b_q + BCW'(1);
          j_d     = '0;
          state_d = S_SR_REQ;
        end else if (j_q == J_LAST) begin
          j_d     = '0;
          spare_d = b_q[BW-1:0];
          state_d = S_CP_REQ;
        end else begin
          j_d     = j_q + OW'(1);
          state_d = S_SR_REQ;
        end
      end
      // home block into spare, new word at its offset
      S_CP_REQ: begin
        ram_raddr_o = {home, j_q};
        state_d     = S_CP_WR;
      end
      S_CP_WR: begin
        ram_waddr_o = {spare_q, j_q};
        if (j_q == off) begin
          ram_we_o    = 1'b1;
          ram_wdata_o = word_q;
          cnt_d       = cnt_q + CNT_W'(1);
        end else if (rd_full) begin
          ram_we_o    = 1'b1;
          ram_wdata_o = ram_rdata_i;
          cnt_d       = cnt_q + CNT_W'(1);
        end
        if (j_q == J_LAST) begin
          j_d     = '0;
          state_d = S_BK_REQ;
        end else begin
          j_d     = j_q + OW'(1);
          state_d = S_CP_REQ;
        end
      end
      // spare block back over the whole home block
      S_BK_REQ: begin
        ram_raddr_o = {spare_q, j_q};
        state_d     = S_BK_WR;
      end
      S_BK_WR: begin
        ram_we_o    = 1'b1;
        ram_waddr_o = {home, j_q};
        ram_wdata_o = ram_rdata_i;
        cnt_d       = cnt_q + CNT_W'(1);
        if (j_q == J_LAST) begin
          j_d     = '0;
          state_d = S_WIPE;
        end else begin
          j_d     = j_q + OW'(1);
          state_d = S_BK_REQ;
        end
      end
      S_WIPE: begin
        ram_we_o    = 1'b1;
        ram_waddr_o = {spare_q, j_q};
        j_d         = j_q + OW'(1);
        if (j_q == J_LAST) begin
          state_d = S_DONE;
        end
      end
      S_ERASE: begin
        ram_we_o    = 1'b1;
        ram_waddr_o = {blk_q, j_q};
        cnt_d       = cnt_q + CNT_W'(1);
        j_d         = j_q + OW'(1);
        if (j_q == J_LAST) begin
          state_d = S_DONE;
        end
      end
      // hand the result to the output register
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_d.status        = status_q;
          out_d.read_data     = rdata_q;
          out_d.program_count = cnt_q;
          out_valid_d         = 1'b1;
          state_d             = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
      b_q         <= '0;
      j_q         <= '0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
      b_q         <= b_d;
      j_q         <= j_d;
    end
  end

  always_ff @(posedge clk_i) begin
    addr_q   <= addr_d;
    blk_q    <= blk_d;
    spare_q  <= spare_d;
    word_q   <= word_d;
    status_q <= status_d;
    rdata_q  <= rdata_d;
    cnt_q    <= cnt_d;
    out_q    <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // an accepted item keeps the input side closed on the next cycle
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input accepted twice in a row");

  // the wipe of the spare and the block erase write zeros only
  a_wipe_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we_o && (state_q == S_WIPE || state_q == S_ERASE) |-> ram_wdata_o == '0)
    else $error("erase wrote nonzero data");

  // a result appears only from the done step
  a_result_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_DONE))
    else $error("result raised outside done step");

endmodule

`default_nettype wire

// File: hw/rtl/block_mapped_flash_rewrite_core.sv
// ----------------------------------------------------------------------------
// block_mapped_flash_rewrite_core: block-mapped flash array with rewrite
// Reads, in-place writes, block erases and full-sector rewrites through the
// lowest free spare block, all over one shared sector-wide ram port.
// ----------------------------------------------------------------------------
// channel  | signals                          | transfer when
// ---------+----------------------------------+-------------------------------
// request  | in_valid_i, in_ready_o, in_data_i   | in_valid_i && in_ready_o
// result   | out_valid_o, out_ready_i, out_data_o| out_valid_o && out_ready_i
// config   | psel, penable, pwrite, paddr, ...   | psel && penable && pwrite
//
// a read goes through request and data steps, an in-place write through request
// and check steps, an erase one sector a step; a rewrite adds the spare search
// and copy, copy back and wipe over each sector of the block: one ram access a step
// after reset the store is cleared one sector a cycle with in_ready_o low;
// config writes are taken meanwhile
// a result waiting on out_ready_i holds the sequencer in its done step
// ----------------------------------------------------------------------------
`default_nettype none

module block_mapped_flash_rewrite_core
  import bmfr_pkg::*;
#(
  parameter int SECTORS_PER_BLOCK_P = SECTORS_PER_BLOCK,
  parameter int NUM_BLOCKS_P        = NUM_BLOCKS,
  parameter int DATA_WIDTH_P        = DATA_WIDTH
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output      logic               in_ready_o,
  input  wire in_req_t            in_data_i,
  output      logic               out_valid_o,
  input  wire logic               out_ready_i,
  output      out_rsp_t           out_data_o,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [PDATA_W-1:0] pwdata,
  output      logic [PDATA_W-1:0] prdata,
  output      logic               pready
);

  localparam int DEPTH = SECTORS_PER_BLOCK_P * NUM_BLOCKS_P;
  localparam int AW    = $clog2(DEPTH);

  logic [BIU_W-1:0]        blocks_in_use;
  logic                    ram_we;
  logic [AW-1:0]           ram_waddr, ram_raddr;
  logic [DATA_WIDTH_P-1:0] ram_wdata, ram_rdata;

  // configuration registers
  bmfr_cfg #(
    .NUM_BLOCKS_P (NUM_BLOCKS_P)
  ) u_cfg (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .blocks_in_use_o (blocks_in_use)
  );

  // operation sequencer
  bmfr_seq #(
    .SECTORS_PER_BLOCK_P (SECTORS_PER_BLOCK_P),
    .NUM_BLOCKS_P        (NUM_BLOCKS_P),
    .DATA_WIDTH_P        (DATA_WIDTH_P)
  ) u_seq (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .blocks_in_use_i (blocks_in_use),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .in_data_i       (in_data_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .out_data_o      (out_data_o),
    .ram_we_o        (ram_we),
    .ram_waddr_o     (ram_waddr),
    .ram_wdata_o     (ram_wdata),
    .ram_raddr_o     (ram_raddr),
    .ram_rdata_i     (ram_rdata)
  );

  // sector store
  bmfr_ram #(
    .WIDTH (DATA_WIDTH_P),
    .DEPTH (DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

endmodule

`default_nettype wire
